@@ src/s5rp_pkg.sv @@
// Package for the SOCKS5 request parser: payload structs, byte and status
// codes, one-hot parse phases and address type constants. No dependencies.
package s5rp_pkg;

	typedef enum logic [2:0] {
		KIND_VERSION  = 3'd0,
		KIND_COMMAND  = 3'd1,
		KIND_RESERVED = 3'd2,
		KIND_ATYPE    = 3'd3,
		KIND_NAMELEN  = 3'd4,
		KIND_ADDR     = 3'd5,
		KIND_PORT     = 3'd6,
		KIND_IGNORED  = 3'd7
	} byte_kind_t;

	typedef enum logic [1:0] {
		ADDR_IPV4 = 2'd0,
		ADDR_NAME = 2'd1,
		ADDR_IPV6 = 2'd2
	} addr_kind_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_REJECTED = 2'd2,
		ST_BADTYPE  = 2'd3
	} parse_status_t;

	typedef enum logic [7:0] {
		PH_VERSION  = 8'b0000_0001,
		PH_COMMAND  = 8'b0000_0010,
		PH_RESERVED = 8'b0000_0100,
		PH_ATYPE    = 8'b0000_1000,
		PH_NAMELEN  = 8'b0001_0000,
		PH_ADDRESS  = 8'b0010_0000,
		PH_PORT     = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	// Address type byte values on the wire
	localparam logic [7:0] ATYP_IPV4 = 8'd1;
	localparam logic [7:0] ATYP_NAME = 8'd3;
	localparam logic [7:0] ATYP_IPV6 = 8'd4;

	localparam logic [7:0] IPV4_BYTES = 8'd4;
	localparam logic [7:0] IPV6_BYTES = 8'd16;

	localparam logic [7:0] ACCEPTED_COMMAND_RESET = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
		logic       new_request;
	} req_t;

	typedef struct packed {
		byte_kind_t    byte_kind;
		logic [7:0]    byte_value;
		logic [7:0]    byte_index;
		addr_kind_t    address_kind;
		parse_status_t parse_status;
		logic          chunk_reply;
	} res_t;

endpackage

@@ src/socks5_request_parser.sv @@
// SOCKS5 request parser top level: one byte in, one labeled result out.
// Depends on s5rp_pkg for payload structs, codes and phases.
//
// Usage:
// - Request channel (req_valid, req_stall, req) carries one byte of the
//   SOCKS5 request stream per request, with chunk_last and new_request flags.
// - Result channel (res_valid, res_stall, res) returns one result per
//   request: byte kind, byte value, index within address or port, address
//   kind and parse status after that byte; chunk_reply copies chunk_last.
// - Config channel (cfg_valid, cfg_ready, cfg_data) writes accepted_command;
//   write only while no request is in flight. cfg_ready is always high.
// - Path: a request is loaded into the input register, parsed from there into
//   the result register, and taken from the result register while res_stall is low.
// - Throughput: one request per cycle while no result is held by res_stall;
//   the parse state (phase, counters, status) updates in short combinational
//   logic between the input register and the result register.
// - Stall: when res_stall holds a result, the input register holds too and
//   req_stall rises only once that register is full; nothing is dropped.
// - Reset: both registers empty, phase expects the version byte, status in
//   progress, accepted_command back to 1.
module socks5_request_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  s5rp_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output s5rp_pkg::res_t res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);
	import s5rp_pkg::*;

	// Input stage
	req_t req_s1;
	logic req_valid_s1;

	// Parse state
	phase_t        phase_q;
	logic [7:0]    count_q;
	logic [7:0]    name_len_q;
	addr_kind_t    addr_kind_q;
	parse_status_t status_q;
	logic [7:0]    accepted_command_q;

	// Result register
	res_t res_q;
	logic res_valid_q;

	logic advance;
	logic req_accept;

	// Current state after an optional clear, and next state
	phase_t        cur_phase,  nxt_phase;
	logic [7:0]    cur_count,  nxt_count;
	logic [7:0]    cur_name_len, nxt_name_len;
	addr_kind_t    cur_addr_kind, nxt_addr_kind;
	parse_status_t cur_status, nxt_status;
	byte_kind_t    kind;
	logic [7:0]    index;
	logic [7:0]    addr_size;
	logic [7:0]    count_inc;
	logic [7:0]    b;

	// Parse the held request whenever the result slot is free or draining
	assign advance    = req_valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall  = req_valid_s1 && !advance;
	assign req_accept = req_valid && !req_stall;
	assign cfg_ready  = 1'b1;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign b = req_s1.data_byte;

	always_comb begin
		// Drop the old parse when this byte opens a new request
		if (req_s1.new_request) begin
			cur_phase     = PH_VERSION;
			cur_count     = 8'd0;
			cur_name_len  = 8'd0;
			cur_addr_kind = ADDR_IPV4;
			cur_status    = ST_BUSY;
		end else begin
			cur_phase     = phase_q;
			cur_count     = count_q;
			cur_name_len  = name_len_q;
			cur_addr_kind = addr_kind_q;
			cur_status    = status_q;
		end

		case (cur_addr_kind)
			ADDR_IPV4: addr_size = IPV4_BYTES;
			ADDR_IPV6: addr_size = IPV6_BYTES;
			default:   addr_size = cur_name_len;
		endcase
		count_inc = cur_count + 8'd1;

		nxt_phase     = cur_phase;
		nxt_count     = cur_count;
		nxt_name_len  = cur_name_len;
		nxt_addr_kind = cur_addr_kind;
		nxt_status    = cur_status;
		kind          = KIND_IGNORED;
		index         = 8'd0;

		if (cur_status == ST_BUSY) begin
			case (cur_phase)
				PH_VERSION: begin
					kind      = KIND_VERSION;
					nxt_phase = PH_COMMAND;
				end
				PH_COMMAND: begin
					kind = KIND_COMMAND;
					if (b != accepted_command_q) begin
						nxt_status = ST_REJECTED;
						nxt_phase  = PH_DONE;
					end else begin
						nxt_phase = PH_RESERVED;
					end
				end
				PH_RESERVED: begin
					kind      = KIND_RESERVED;
					nxt_phase = PH_ATYPE;
				end
				PH_ATYPE: begin
					kind      = KIND_ATYPE;
					nxt_count = 8'd0;
					case (b)
						ATYP_IPV4: begin
							nxt_addr_kind = ADDR_IPV4;
							nxt_phase     = PH_ADDRESS;
						end
						ATYP_NAME: begin
							nxt_addr_kind = ADDR_NAME;
							nxt_phase     = PH_NAMELEN;
						end
						ATYP_IPV6: begin
							nxt_addr_kind = ADDR_IPV6;
							nxt_phase     = PH_ADDRESS;
						end
						default: begin
							nxt_status = ST_BADTYPE;
							nxt_phase  = PH_DONE;
						end
					endcase
				end
				PH_NAMELEN: begin
					kind         = KIND_NAMELEN;
					nxt_name_len = b;
					nxt_count    = 8'd0;
					// An empty name goes straight to the port
					nxt_phase    = (b == 8'd0) ? PH_PORT : PH_ADDRESS;
				end
				PH_ADDRESS: begin
					kind  = KIND_ADDR;
					index = cur_count;
					if (count_inc == addr_size) begin
						nxt_count = 8'd0;
						nxt_phase = PH_PORT;
					end else begin
						nxt_count = count_inc;
					end
				end
				PH_PORT: begin
					kind  = KIND_PORT;
					index = cur_count;
					if (cur_count != 8'd0) begin
						nxt_count  = 8'd0;
						nxt_status = ST_COMPLETE;
						nxt_phase  = PH_DONE;
					end else begin
						nxt_count = 8'd1;
					end
				end
				default: begin
					// Done or unreachable phase: ignore the byte, hold state
					kind = KIND_IGNORED;
				end
			endcase
		end
	end

	// Input register: load on accept, empty once parsed with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1 <= req;
		end
	end

	// Parse state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_VERSION;
			count_q            <= 8'd0;
			name_len_q         <= 8'd0;
			addr_kind_q        <= ADDR_IPV4;
			status_q           <= ST_BUSY;
			accepted_command_q <= ACCEPTED_COMMAND_RESET;
		end else begin
			if (advance) begin
				phase_q     <= nxt_phase;
				count_q     <= nxt_count;
				name_len_q  <= nxt_name_len;
				addr_kind_q <= nxt_addr_kind;
				status_q    <= nxt_status;
			end
			if (cfg_valid && cfg_ready) begin
				accepted_command_q <= cfg_data;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.byte_kind    <= kind;
			res_q.byte_value   <= b;
			res_q.byte_index   <= index;
			res_q.address_kind <= nxt_addr_kind;
			res_q.parse_status <= nxt_status;
			res_q.chunk_reply  <= req_s1.chunk_last;
		end
	end

endmodule
